### rtl/core/mpi_pkg.sv
package mpi_pkg;

	// field widths
	localparam int BASE_W = 30;
	localparam int RES_W  = 30;
	localparam int OUT_W  = 32;
	localparam int OPD_W  = 31;
	localparam int PROD_W = 2 * OPD_W;
	localparam int RED_W  = 32;

	// prime modulus and derived constants
	localparam logic [BASE_W-1:0] PRIME    = 30'd1000000007;
	localparam logic [BASE_W-1:0] PRIME_M2 = 30'd1000000005;
	localparam logic [RED_W-1:0]  PRIME_X1 = 32'd1000000007;
	localparam logic [RED_W-1:0]  PRIME_X2 = 32'd2000000014;

	// barrett factor floor(2^60 / prime)
	localparam logic [OPD_W-1:0] BARRETT_MU = 31'd1152921496;

	// action codes
	localparam logic ACT_POWER   = 1'b0;
	localparam logic ACT_INVERSE = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_QEST,
		ST_QMUL,
		ST_CORR,
		ST_OUT
	} state_t;

endpackage

### rtl/core/modular_power_and_inverse_unit.sv
// Modular power and inverse modulo the prime 1000000007. Each input transaction
// carries a base (below 2^30, reduced once on entry), an exponent and an action in
// tuser: 0 raises base to the exponent, 1 returns the inverse (base to the prime
// minus 2, exponent ignored; the inverse of 0 is 0). Exponent 0 gives 1. The
// exponent is scanned from its top bit by square-and-multiply on a single shared
// 31x31 multiplier; each modular product is a Barrett reduction through the
// states product, quotient estimate, quotient times prime and correction. The
// input is taken only while no item is in work; a finished result waits in an
// output register, so the next item may start while the previous result is
// still pending.
module modular_power_and_inverse_unit #(
	parameter int EXP_WIDTH = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	// base [29:0], exponent [EXP_WIDTH+29:30], zero padding above
	input  logic [((mpi_pkg::BASE_W+EXP_WIDTH+7)/8)*8-1:0] s_tdata,
	// action [0]
	input  logic                                           s_tuser,
	output logic                                           m_tvalid,
	input  logic                                           m_tready,
	// result [29:0], zero padding above
	output logic [mpi_pkg::OUT_W-1:0]                      m_tdata
);

	import mpi_pkg::*;

	localparam int CNT_W = $clog2(EXP_WIDTH + 1);

	state_t               state_q, state_d;
	logic [RES_W-1:0]     acc_q;
	logic [BASE_W-1:0]    base_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 mulb_q;
	logic [PROD_W-1:0]    prod_q;
	logic [RED_W-1:0]     xlo_q;
	logic [RES_W-1:0]     res_q;
	logic                 out_valid_q;

	logic [OPD_W-1:0]     mul_a, mul_b;
	logic [PROD_W-1:0]    mul_p;
	logic [RED_W-1:0]     corr_raw, corr_r;
	logic [BASE_W-1:0]    base_in, base_red;
	logic [EXP_WIDTH-1:0] exp_in;
	logic                 in_acc, mul_step, last_bit, out_free;

	// input decode and reduction of the base
	assign base_in  = s_tdata[BASE_W-1:0];
	assign base_red = (base_in >= PRIME) ? (base_in - PRIME) : base_in;
	assign exp_in   = (s_tuser == ACT_INVERSE) ? EXP_WIDTH'(PRIME_M2)
		: s_tdata[BASE_W +: EXP_WIDTH];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign mul_step = !mulb_q && exp_q[EXP_WIDTH-1];
	assign last_bit = (cnt_q == CNT_W'(1));
	assign out_free = !out_valid_q || m_tready;

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL: begin
				mul_a = OPD_W'(acc_q);
				mul_b = mulb_q ? OPD_W'(base_q) : OPD_W'(acc_q);
			end
			ST_QEST: begin
				mul_a = prod_q[59:29];
				mul_b = BARRETT_MU;
			end
			ST_QMUL: begin
				mul_a = prod_q[PROD_W-1:OPD_W];
				mul_b = OPD_W'(PRIME);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// barrett correction, remainder below three times the prime
	assign corr_raw = xlo_q - prod_q[RED_W-1:0];
	always_comb begin
		if (corr_raw >= PRIME_X2) begin
			corr_r = corr_raw - PRIME_X2;
		end else if (corr_raw >= PRIME_X1) begin
			corr_r = corr_raw - PRIME_X1;
		end else begin
			corr_r = corr_raw;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_QEST;
			ST_QEST: state_d = ST_QMUL;
			ST_QMUL: state_d = ST_CORR;
			ST_CORR: begin
				if (mul_step) state_d = ST_MUL;
				else if (last_bit) state_d = ST_OUT;
				else state_d = ST_MUL;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// exponent scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mulb_q <= 1'b0;
		end else if (in_acc) begin
			cnt_q  <= CNT_W'(EXP_WIDTH);
			mulb_q <= 1'b0;
		end else if (state_q == ST_CORR) begin
			if (mul_step) begin
				mulb_q <= 1'b1;
			end else begin
				mulb_q <= 1'b0;
				cnt_q  <= cnt_q - CNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_acc) begin
			base_q <= base_red;
			exp_q  <= exp_in;
			acc_q  <= RES_W'(1);
		end
		if (state_q == ST_QEST) xlo_q <= prod_q[RED_W-1:0];
		if (state_q == ST_CORR) begin
			acc_q <= corr_r[RES_W-1:0];
			if (!mul_step) exp_q <= exp_q << 1;
		end
		if (state_q == ST_OUT && out_free) res_q <= acc_q;
	end

	// output holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(res_q);

	// running value stays reduced at the start of every product
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> acc_q < PRIME)
		else $error("running value not reduced");

	// corrected remainder is always below the prime
	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORR |-> corr_r < PRIME_X1)
		else $error("barrett correction out of range");

	// bit counter never runs out while a product is in work
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_CORR) |-> cnt_q != '0)
		else $error("exponent bit counter exhausted");

	// an accepted transaction starts with a product
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_MUL && acc_q == RES_W'(1))
		else $error("item start not taken");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import mpi_pkg::*;

	localparam int EXP_W = 32;
	localparam int TDATA_W = ((BASE_W + EXP_W + 7) / 8) * 8;
	localparam longint unsigned MOD_P = 64'(PRIME);
	localparam logic [BASE_W-1:0] BASE_TOP = '1;
	localparam int RANDOM_ITEMS = 1450;
	localparam int IDLE_PCT = 35;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 3000;
	localparam int STEADY_LO = 600;
	localparam int STEADY_HI = 800;

	typedef struct packed {
		logic              action;
		logic [BASE_W-1:0] base;
		logic [EXP_W-1:0]  exponent;
	} power_req_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// base [29:0], exponent [61:30], zero padding above
	logic [TDATA_W-1:0] s_tdata = '0;
	// action [0]
	logic               s_tuser = ACT_POWER;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// result [29:0], zero padding above
	logic [OUT_W-1:0]   m_tdata;

	power_req_t        pending_reqs[$];
	logic [RES_W-1:0]  expected_powers[$];
	power_req_t        req_on_bus;
	int                total_reqs = 0;
	int                reqs_sent = 0;
	int                results_seen = 0;
	int                mismatches = 0;
	int                hold_left = 0;
	bit                hold_done = 1'b0;
	int                cycle_count = 0;

	modular_power_and_inverse_unit #(
		.EXP_WIDTH(EXP_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// square-and-multiply from the top exponent bit, with the base reduced once
	function automatic logic [RES_W-1:0] mod_power(logic act, logic [BASE_W-1:0] b,
			logic [EXP_W-1:0] e);
		longint unsigned acc;
		longint unsigned bb;
		logic [EXP_W-1:0] ee;
		int i;
		bb = 64'(b);
		if (bb >= MOD_P)
			bb = bb - MOD_P;
		ee = (act == ACT_INVERSE) ? EXP_W'(MOD_P - 2) : e;
		acc = 1;
		for (i = EXP_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % MOD_P;
			if (ee[i])
				acc = (acc * bb) % MOD_P;
		end
		return acc[RES_W-1:0];
	endfunction

	task automatic add_req(logic act, logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
		power_req_t r;
		r.action   = act;
		r.base     = b;
		r.exponent = e;
		pending_reqs = {pending_reqs, r};
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset held for the first cycles only
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// source side: offer queued requests, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= ACT_POWER;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_powers = {expected_powers, mod_power(req_on_bus.action,
					req_on_bus.base, req_on_bus.exponent)};
				reqs_sent <= reqs_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 &&
						((reqs_sent >= STEADY_LO && reqs_sent < STEADY_HI) ||
						$urandom_range(99) >= IDLE_PCT)) begin
					req_on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= TDATA_W'({req_on_bus.exponent, req_on_bus.base});
					s_tuser  <= req_on_bus.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: compare each result transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_powers.size() == 0) begin
					$display("%0t: result 0x%08h with nothing expected", $time, m_tdata);
					mismatches++;
				end else begin
					logic [RES_W-1:0] want;
					want = expected_powers.pop_front();
					if (m_tdata !== OUT_W'(want)) begin
						$display("%0t: result mismatch, expected %0d, actual %0d (0x%08h)",
							$time, want, m_tdata, m_tdata);
						mismatches++;
					end
				end
				results_seen <= results_seen + 1;
			end
			// one long hold-off so the unit backs up onto its input
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else if (results_seen >= STEADY_LO && results_seen < STEADY_HI) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// stimulus and end of run
	initial begin
		int n;
		int sel;
		logic act;
		logic [BASE_W-1:0] b;
		logic [EXP_W-1:0] e;

		// directed: zero exponent, inverse of zero, unreduced bases, extreme fields
		add_req(ACT_POWER, '0, '0);
		add_req(ACT_POWER, 30'd12345, '0);
		add_req(ACT_POWER, '0, 32'd5);
		add_req(ACT_POWER, 30'd2, 32'd1);
		add_req(ACT_POWER, BASE_TOP, '1);
		add_req(ACT_POWER, BASE_TOP, '0);
		add_req(ACT_POWER, PRIME, 32'd3);
		add_req(ACT_POWER, PRIME, '0);
		add_req(ACT_POWER, PRIME - 30'd1, '1);
		add_req(ACT_POWER, 30'd1, 32'h8000_0000);
		add_req(ACT_POWER, 30'h2AAA_AAAA, 32'hAAAA_AAAA);
		add_req(ACT_POWER, 30'h1555_5555, 32'h5555_5555);
		add_req(ACT_INVERSE, '0, '1);
		add_req(ACT_INVERSE, 30'd1, '0);
		add_req(ACT_INVERSE, 30'd2, 32'h1234_5678);
		add_req(ACT_INVERSE, PRIME - 30'd1, '0);
		add_req(ACT_INVERSE, BASE_TOP, '1);
		add_req(ACT_INVERSE, PRIME, 32'd7);

		// random mix with weight on the corners
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(99);
			act = ($urandom_range(99) < 25) ? ACT_INVERSE : ACT_POWER;
			b   = BASE_W'($urandom());
			e   = $urandom();
			if (sel < 15) begin
				e = $urandom_range(20);
			end else if (sel < 25) begin
				b = PRIME + BASE_W'($urandom_range(int'(BASE_TOP - PRIME)));
			end else if (sel < 35) begin
				case ($urandom_range(2))
					0: begin
						b = '0;
					end
					1: begin
						b = 30'd1;
					end
					default: begin
						b = PRIME - 30'd1;
					end
				endcase
			end else if (sel < 40) begin
				e = ~EXP_W'($urandom_range(15));
			end
			add_req(act, b, e);
		end
		total_reqs = pending_reqs.size();

		@(posedge arst_n);
		while (reqs_sent < total_reqs)
			@(negedge clk);
		while (expected_powers.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
